FILE: rtl/sui_pkg.sv
// Package for the set union and intersection block: widths, codes, command
// and status structures, and the bit search used by the datapath.
// Depends on nothing.
package sui_pkg;

    localparam int VALUE_W    = 17;
    localparam int MAX_VALUE  = 131071;
    localparam int FUNC_W     = 3;
    localparam int LO_W       = 6;
    localparam int WORD_BITS  = 1 << LO_W;
    localparam int WORD_AW    = VALUE_W - LO_W;
    localparam int WORD_DEPTH = 1 << WORD_AW;
    localparam int RAM_W      = 2 * WORD_BITS;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INS_A = 3'd0,
        FUNC_INS_B = 3'd1,
        FUNC_UNION = 3'd2,
        FUNC_INTER = 3'd3,
        FUNC_CLEAR = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ZERO,
        RES_INS,
        RES_END,
        RES_HIT
    } t_res;

    typedef struct packed {
        logic accept;
        logic ins_rd;
        logic ins_wr;
        logic scan_init;
        logic scan_rd;
        logic scan_next;
        logic clr_init;
        logic clr_step;
        t_res res;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_insert;
        logic is_scan;
        logic is_clear;
        logic ins_ok;
        logic past_end;
        logic hit;
        logic last_word;
        logic out_free;
    } t_dp_sts;

    function automatic logic [LO_W-1:0] f_lowest(input logic [WORD_BITS-1:0] vec);
        logic [LO_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = LO_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/sui_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on sui_pkg.
interface sui_in_if import sui_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] item_value;

    modport source (output valid, output func, output item_value, input ready);
    modport sink (input valid, input func, input item_value, output ready);
endinterface

interface sui_out_if import sui_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] out_value;
    logic               has_value;
    logic               list_done;

    modport source (output valid, output out_value, output has_value, output list_done,
                    input ready);
    modport sink (input valid, input out_value, input has_value, input list_done,
                  output ready);
endinterface

FILE: rtl/set_union_intersection.sv
// Top level of the set union and intersection block.
// Depends on sui_pkg, sui_if, sui_ctrl and sui_dp.
//
// Usage: items arrive on i_in (func, item_value) and one result item per
// input item leaves on o_out (out_value, has_value, list_done), both with
// valid/ready handshakes. Inserts set a presence bit for A or B; union and
// intersection requests return the next member above their own cursor.
// The bitmap is stored as 2048 words of 64 values, A and B bits side by side.
// An accepted insert reads its bitmap word and then writes it back; a rejected
// insert, an unused code or a request whose cursor is already at the end
// goes straight to its result. A request reads and checks one bitmap word
// after another until it finds a member or reaches the last word; each word
// takes a read state and a check state, set by the registered read of the RAM.
// A clear command sweeps all 2048 words.
// One item is processed at a time; the next is taken once the result has
// been placed in the output register, even if that result is still waiting.
// After reset the block clears the bitmap with ready low. If the receiver
// stalls, the result is held and a further finished result waits inside the
// block until the output register frees.
module set_union_intersection import sui_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    sui_in_if.sink     i_in,
    sui_out_if.source  o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sui_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sui_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_func       (i_in.func),
        .i_item_value (i_in.item_value),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_value  (o_out.out_value),
        .o_has_value  (o_out.has_value),
        .o_list_done  (o_out.list_done)
    );

endmodule

FILE: rtl/sui_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module sui_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sui_dp.sv
// Datapath: presence bitmap memory, read cursors, word scan and result registers.
// Depends on sui_pkg and sui_ram.
module sui_dp import sui_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [VALUE_W-1:0] i_item_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [VALUE_W-1:0] o_out_value,
    output logic               o_has_value,
    output logic               o_list_done
);

    logic [FUNC_W-1:0]    r_func;
    logic [VALUE_W-1:0]   r_value;
    logic [WORD_AW-1:0]   r_addr;
    logic [LO_W-1:0]      r_lo;
    logic [VALUE_W-1:0]   r_ucur;
    logic [VALUE_W-1:0]   r_icur;
    logic [VALUE_W-1:0]   r_res_value;
    logic                 r_res_has;
    logic                 r_res_done;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_value;
    logic                 r_out_has;
    logic                 r_out_done;

    logic [RAM_W-1:0]     w_rdata;
    logic [RAM_W-1:0]     w_wdata;
    logic [WORD_BITS-1:0] w_a;
    logic [WORD_BITS-1:0] w_b;
    logic [WORD_BITS-1:0] w_sel;
    logic [WORD_BITS-1:0] w_masked;
    logic [WORD_BITS-1:0] w_onehot;
    logic [LO_W-1:0]      w_idx;
    logic [VALUE_W-1:0]   w_hit_value;
    logic [VALUE_W-1:0]   w_cur;
    logic [VALUE_W:0]     w_start;
    logic                 w_is_union;
    logic                 w_we;
    logic                 w_re;

    assign w_is_union  = (r_func == FUNC_UNION);
    assign w_a         = w_rdata[WORD_BITS-1:0];
    assign w_b         = w_rdata[RAM_W-1:WORD_BITS];
    assign w_sel       = w_is_union ? (w_a | w_b) : (w_a & w_b);
    assign w_masked    = w_sel & ({WORD_BITS{1'b1}} << r_lo);
    assign w_idx       = f_lowest(w_masked);
    assign w_hit_value = {r_addr, w_idx};
    assign w_cur       = w_is_union ? r_ucur : r_icur;
    assign w_start     = {1'b0, w_cur} + (VALUE_W+1)'(1);
    assign w_onehot    = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_value[LO_W-1:0];

    always_comb begin
        if (i_cmd.clr_step) begin
            w_wdata = '0;
        end else if (r_func == FUNC_INS_A) begin
            w_wdata = {w_b, w_a | w_onehot};
        end else begin
            w_wdata = {w_b | w_onehot, w_a};
        end
    end

    assign w_we = i_cmd.clr_step | i_cmd.ins_wr;
    assign w_re = i_cmd.ins_rd | i_cmd.scan_rd;

    sui_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WORD_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_sts.is_insert = (r_func == FUNC_INS_A) || (r_func == FUNC_INS_B);
        o_sts.is_scan   = (r_func == FUNC_UNION) || (r_func == FUNC_INTER);
        o_sts.is_clear  = (r_func == FUNC_CLEAR);
        o_sts.ins_ok    = (r_value != '0) &&
                          ({1'b0, r_value} <= (VALUE_W+1)'(MAX_VALUE));
        o_sts.past_end  = (w_start > (VALUE_W+1)'(MAX_VALUE));
        o_sts.hit       = |w_masked;
        o_sts.last_word = &r_addr;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ucur      <= '0;
            r_icur      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_init) begin
                r_ucur <= '0;
                r_icur <= '0;
            end else if (i_cmd.res == RES_HIT) begin
                if (w_is_union) begin
                    r_ucur <= w_hit_value;
                end else begin
                    r_icur <= w_hit_value;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_func;
            r_value <= i_item_value;
            r_addr  <= i_item_value[VALUE_W-1:LO_W];
        end else if (i_cmd.clr_init) begin
            r_addr <= '0;
        end else if (i_cmd.clr_step || i_cmd.scan_next) begin
            r_addr <= r_addr + WORD_AW'(1);
        end else if (i_cmd.scan_init) begin
            r_addr <= w_start[VALUE_W-1:LO_W];
        end
        if (i_cmd.scan_init) begin
            r_lo <= w_start[LO_W-1:0];
        end else if (i_cmd.scan_next) begin
            r_lo <= '0;
        end
        case (i_cmd.res)
            RES_ZERO: begin
                r_res_value <= '0;
                r_res_has   <= 1'b0;
                r_res_done  <= 1'b0;
            end
            RES_INS: begin
                r_res_value <= '0;
                r_res_has   <= 1'b1;
                r_res_done  <= 1'b0;
            end
            RES_END: begin
                r_res_value <= '0;
                r_res_has   <= 1'b0;
                r_res_done  <= 1'b1;
            end
            RES_HIT: begin
                r_res_value <= w_hit_value;
                r_res_has   <= 1'b1;
                r_res_done  <= 1'b0;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_value <= r_res_value;
            r_out_has   <= r_res_has;
            r_out_done  <= r_res_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_has_value = r_out_has;
    assign o_list_done = r_out_done;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("A result was loaded over one that had not been taken.");

    a_hit_above_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res == RES_HIT) |-> (w_hit_value > w_cur))
        else $error("A scan returned a value that is not above its cursor.");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("The bitmap was read and written in the same cycle.");

endmodule

FILE: rtl/sui_ctrl.sv
// Controller: state machine that sequences inserts, scans and clearing passes.
// Depends on sui_pkg.
module sui_ctrl import sui_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_CLR_RST,
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_CLR_CMD,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_cmd.res = RES_NONE;
        case (r_state)
            ST_INIT: begin
                o_cmd.clr_init = 1'b1;
                n_state        = ST_CLR_RST;
            end
            ST_CLR_RST: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.last_word) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_sts.is_insert) begin
                    if (i_sts.ins_ok) begin
                        o_cmd.ins_rd = 1'b1;
                        n_state      = ST_INS_WR;
                    end else begin
                        o_cmd.res = RES_ZERO;
                        n_state   = ST_FIN;
                    end
                end else if (i_sts.is_scan) begin
                    o_cmd.scan_init = 1'b1;
                    if (i_sts.past_end) begin
                        o_cmd.res = RES_END;
                        n_state   = ST_FIN;
                    end else begin
                        n_state = ST_SCAN_RD;
                    end
                end else if (i_sts.is_clear) begin
                    o_cmd.clr_init = 1'b1;
                    n_state        = ST_CLR_CMD;
                end else begin
                    o_cmd.res = RES_ZERO;
                    n_state   = ST_FIN;
                end
            end
            ST_INS_WR: begin
                o_cmd.ins_wr = 1'b1;
                o_cmd.res    = RES_INS;
                n_state      = ST_FIN;
            end
            ST_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (i_sts.hit) begin
                    o_cmd.res = RES_HIT;
                    n_state   = ST_FIN;
                end else if (i_sts.last_word) begin
                    o_cmd.res = RES_END;
                    n_state   = ST_FIN;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = ST_SCAN_RD;
                end
            end
            ST_CLR_CMD: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.last_word) begin
                    o_cmd.res = RES_ZERO;
                    n_state   = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_DISPATCH))
        else $error("An accepted item was not dispatched.");

    a_fin_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && i_sts.out_free) |=> o_in_ready)
        else $error("The controller did not return to idle after delivering a result.");

endmodule
